// ===== src/hslrgb_pkg.sv =====
// Shared types, constants and helpers for the HSL to RGB converter.
// No dependencies; every other file imports this package.
package hslrgb_pkg;

    // Field widths fixed by the interface
    localparam int HUE_W  = 9;
    localparam int SL_W   = 11;
    localparam int CHAN_W = 8;

    // Pipeline depth and stage indices
    localparam int NSTG      = 8;
    localparam int STG_IN    = 0;   // operands captured, L*S product
    localparam int STG_HI    = 1;   // upper chroma bound, hue factors
    localparam int STG_BND   = 2;   // lower bound and bound difference
    localparam int STG_MUL   = 3;   // lo*60 and diff*factor
    localparam int STG_NUM   = 4;   // ramp numerator
    localparam int STG_X255  = 5;   // numerator * 255
    localparam int STG_CLAMP = 6;   // saturate / zero decision, quotient digits
    localparam int STG_OUT   = 7;   // divide by 15, final channel

    typedef struct packed {
        logic [NSTG-1:0] load;      // per stage register enable
    } stg_ctl_t;

    // Hue position arithmetic, signed, covers -120 .. 631
    localparam int HP_W = 11;
    localparam int HF_W = 6;        // ramp factor 0 .. 60

    localparam logic signed [HP_W-1:0] HUE_SPAN     = 11'sd360;
    localparam logic signed [HP_W-1:0] HUE_THIRD    = 11'sd120;
    localparam logic signed [HP_W-1:0] HUE_RISE_END = 11'sd60;
    localparam logic signed [HP_W-1:0] HUE_HOLD_END = 11'sd180;
    localparam logic signed [HP_W-1:0] HUE_FALL_END = 11'sd240;
    localparam logic [HF_W-1:0]        FACTOR_FULL  = 6'd60;

    // Channel quotient: q = floor(num*255 / 2^2F); channel = floor(q / 60)
    localparam int               CHQ_W      = 14;
    localparam logic [CHQ_W-1:0] CHAN_SAT_Q = 14'd15360;    // 256 * 60
    localparam int               DIVX_W     = 12;           // q / 4 < 3840
    localparam int               DIV15_W    = 13;
    localparam logic [DIV15_W-1:0] DIV15_MUL = 13'd4370;    // ceil(2^16 / 15)
    localparam int               DIV15_SH   = 16;
    localparam int               DIVP_W     = DIVX_W + DIV15_W;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;

    // Signed width holding both chroma bounds for a given fraction width
    function automatic int bnd_w(input int frac);
        int pw;
        pw = SL_W + frac;
        return ((pw > 2 * SL_W) ? pw : 2 * SL_W) + 3;
    endfunction

    // Ramp factor (0..60) for an unwrapped hue position in degrees
    function automatic logic [HF_W-1:0] hue_factor(input logic signed [HP_W-1:0] pos);
        logic signed [HP_W-1:0] p;
        logic signed [HP_W-1:0] fall;
        p = pos;
        if (p < 0) begin
            p = p + HUE_SPAN;
        end
        if (p > HUE_SPAN) begin
            p = p - HUE_SPAN;
        end
        fall = HUE_FALL_END - p;
        priority if (p < HUE_RISE_END) begin
            return p[HF_W-1:0];
        end else if (p < HUE_HOLD_END) begin
            return FACTOR_FULL;
        end else if (p < HUE_FALL_END) begin
            return fall[HF_W-1:0];
        end else begin
            return '0;
        end
    endfunction

endpackage

// ===== src/hslrgb_flow.sv =====
// Valid tracking and per-stage load enables for the converter pipeline.
// Depends on hslrgb_pkg.
module hslrgb_flow import hslrgb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output stg_ctl_t ctl
);

    logic [NSTG-1:0] valid_reg, valid_next;
    logic [NSTG-1:0] load;
    logic [NSTG-1:0] upstream;

    // A stage loads when it is empty or the stage after it moves on;
    // bubbles close up even while the output is stalled.
    always_comb begin
        load[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign upstream   = {valid_reg[NSTG-2:0], s_valid};
    assign valid_next = (load & upstream) | (~load & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready  = load[STG_IN];
    assign m_valid  = valid_reg[NSTG-1];
    assign ctl.load = load;

endmodule

// ===== src/hslrgb_bounds.sv =====
// Front stages: chroma bounds hi/lo and per-channel hue ramp factors.
// Depends on hslrgb_pkg.
module hslrgb_bounds import hslrgb_pkg::*; #(
    parameter int SL_FRAC_BITS = 10
) (
    input  logic                         aclk,
    input  stg_ctl_t                     ctl,
    input  logic [HUE_W-1:0]             hue,
    input  logic [SL_W-1:0]              sat,
    input  logic [SL_W-1:0]              lit,
    output logic signed [bnd_w(SL_FRAC_BITS)-1:0] lo_o,
    output logic signed [bnd_w(SL_FRAC_BITS):0]   diff_o,
    output logic [2:0][HF_W-1:0]         fac_o
);

    localparam int F    = SL_FRAC_BITS;
    localparam int BW   = bnd_w(F);
    localparam int DW   = BW + 1;
    localparam int LS_W = 2 * SL_W;
    localparam int HALF = 1 << (F - 1);

    // stage: operand capture
    logic [HUE_W-1:0] h1_reg;
    logic [SL_W-1:0]  l1_reg, s1_reg;
    logic [LS_W-1:0]  ls1_reg, ls1_next;

    // stage: upper bound
    logic signed [BW-1:0] hi2_reg, hi2_next;
    logic [SL_W-1:0]      l2_reg;
    logic [2:0][HF_W-1:0] f2_reg, f2_next;

    // stage: lower bound and difference
    logic signed [BW-1:0] lo3_reg, lo3_next;
    logic signed [DW-1:0] d3_reg, d3_next;
    logic [2:0][HF_W-1:0] f3_reg;

    logic signed [BW-1:0]   l_one, s_one, ls_ext, l2_one;
    logic signed [HP_W-1:0] hpos;
    logic                   l_small;

    assign ls1_next = LS_W'(lit) * LS_W'(sat);

    assign l_one   = signed'(BW'(l1_reg) << F);
    assign s_one   = signed'(BW'(s1_reg) << F);
    assign ls_ext  = signed'(BW'(ls1_reg));
    assign l_small = 32'(l1_reg) < HALF;

    // hi = L(1+S) below one half, L+S-LS otherwise; 2F fraction bits
    assign hi2_next = l_small ? (l_one + ls_ext) : (l_one + s_one - ls_ext);

    assign hpos = signed'(HP_W'(h1_reg));
    always_comb begin
        f2_next[0] = hue_factor(hpos + HUE_THIRD);   // red
        f2_next[1] = hue_factor(hpos);               // green
        f2_next[2] = hue_factor(hpos - HUE_THIRD);   // blue
    end

    assign l2_one   = signed'(BW'(l2_reg) << F);
    assign lo3_next = (l2_one <<< 1) - hi2_reg;
    // hi - lo = 2hi - 2L
    assign d3_next  = (DW'(hi2_reg) <<< 1) - (DW'(l2_one) <<< 1);

    always_ff @(posedge aclk) begin
        if (ctl.load[STG_IN]) begin
            h1_reg  <= hue;
            l1_reg  <= lit;
            s1_reg  <= sat;
            ls1_reg <= ls1_next;
        end
        if (ctl.load[STG_HI]) begin
            hi2_reg <= hi2_next;
            l2_reg  <= l1_reg;
            f2_reg  <= f2_next;
        end
        if (ctl.load[STG_BND]) begin
            lo3_reg <= lo3_next;
            d3_reg  <= d3_next;
            f3_reg  <= f2_reg;
        end
    end

    assign lo_o   = lo3_reg;
    assign diff_o = d3_reg;
    assign fac_o  = f3_reg;

endmodule

// ===== src/hslrgb_lane.sv =====
// One colour channel: ramp numerator, scale by 255, exact divide and clamp.
// Depends on hslrgb_pkg.
module hslrgb_lane import hslrgb_pkg::*; #(
    parameter int SL_FRAC_BITS = 10
) (
    input  logic                                  aclk,
    input  stg_ctl_t                              ctl,
    input  logic signed [bnd_w(SL_FRAC_BITS)-1:0] lo_i,
    input  logic signed [bnd_w(SL_FRAC_BITS):0]   diff_i,
    input  logic [HF_W-1:0]                       fac_i,
    output logic [CHAN_W-1:0]                     chan_o
);

    localparam int F   = SL_FRAC_BITS;
    localparam int BW  = bnd_w(F);
    localparam int NW  = BW + 7;
    localparam int PW2 = NW + 8;
    localparam int QW  = PW2 - 2 * F;
    localparam int QXW = (QW > CHQ_W) ? QW : CHQ_W;

    logic signed [NW-1:0]  base_reg, base_next, prod_reg, prod_next;
    logic signed [NW-1:0]  num_reg, num_next;
    logic signed [PW2-1:0] p255_reg, p255_next;
    logic                  pos_reg;
    logic                  zero_reg, sat_reg;
    logic [DIVX_W-1:0]     x_reg;
    logic [CHAN_W-1:0]     chan_reg, chan_next;
    logic [QXW-1:0]        q;
    logic [DIVP_W-1:0]     mq;

    // lo*60 as lo*64 - lo*4
    assign base_next = (NW'(lo_i) <<< 6) - (NW'(lo_i) <<< 2);
    assign prod_next = NW'(diff_i) * NW'(signed'({1'b0, fac_i}));
    assign num_next  = base_reg + prod_reg;
    assign p255_next = (PW2'(num_reg) <<< 8) - PW2'(num_reg);

    // numerator over 60*2^2F: drop 2F bits first, then divide by 60
    assign q = QXW'(p255_reg[PW2-1:2*F]);

    // q/60 = (q/4)/15, reciprocal multiply exact for q/4 < 3840
    assign mq = DIVP_W'(x_reg) * DIVP_W'(DIV15_MUL);

    always_comb begin
        priority if (zero_reg) begin
            chan_next = '0;
        end else if (sat_reg) begin
            chan_next = CHAN_MAX;
        end else begin
            chan_next = mq[DIV15_SH +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[STG_MUL]) begin
            base_reg <= base_next;
            prod_reg <= prod_next;
        end
        if (ctl.load[STG_NUM]) begin
            num_reg <= num_next;
        end
        if (ctl.load[STG_X255]) begin
            p255_reg <= p255_next;
            pos_reg  <= num_reg > 0;
        end
        if (ctl.load[STG_CLAMP]) begin
            zero_reg <= !pos_reg;
            sat_reg  <= q >= QXW'(CHAN_SAT_Q);
            x_reg    <= q[CHQ_W-1:2];
        end
        if (ctl.load[STG_OUT]) begin
            chan_reg <= chan_next;
        end
    end

    assign chan_o = chan_reg;

endmodule

// ===== src/hsl_to_rgb_converter.sv =====
// Top level of the HSL to RGB pixel converter.
// Depends on hslrgb_pkg, hslrgb_flow, hslrgb_bounds and hslrgb_lane.
//
// Usage
//   s_ channel: one HSL word per handshake; hue in whole degrees (0..359),
//   saturation and lightness unsigned with SL_FRAC_BITS fraction bits.
//   m_ channel: one RGB word per input word, 8 bits per channel, truncated
//   and clamped to 0..255. Words leave in the order they arrive.
//   m_valid rises once a word has passed through every stage register, and
//   the word can then be taken. Throughput: one word per clock while the
//   output is not stalled, set by the eight-stage
//   pipeline (bounds, hue factors, ramp multiply, x255, divide by 60).
//   Each stage holds its own valid bit; a stage loads whenever it is empty
//   or its successor moves, so bubbles close up while m_ready is low and
//   s_ready stays high until every stage is full. With m_ready high,
//   s_ready is high.
//   Reset (aresetn low, synchronous) empties the pipeline: m_valid drops,
//   data registers keep whatever they held and are never shown.
//   A stalled output word holds steady until taken; nothing is lost or
//   repeated. No state is kept between words.
module hsl_to_rgb_converter import hslrgb_pkg::*; #(
    parameter int SL_FRAC_BITS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [HUE_W-1:0]  s_hue_degrees,
    input  logic [SL_W-1:0]   s_saturation,
    input  logic [SL_W-1:0]   s_lightness,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAN_W-1:0] m_red,
    output logic [CHAN_W-1:0] m_green,
    output logic [CHAN_W-1:0] m_blue
);

    localparam int BW = bnd_w(SL_FRAC_BITS);

    stg_ctl_t             ctl;
    logic signed [BW-1:0] bnd_lo;
    logic signed [BW:0]   bnd_diff;
    logic [2:0][HF_W-1:0] bnd_fac;

    // valid bits and stage enables
    hslrgb_flow u_flow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    // shared front end: chroma bounds and the three hue ramp factors
    hslrgb_bounds #(
        .SL_FRAC_BITS (SL_FRAC_BITS)
    ) u_bounds (
        .aclk   (aclk),
        .ctl    (ctl),
        .hue    (s_hue_degrees),
        .sat    (s_saturation),
        .lit    (s_lightness),
        .lo_o   (bnd_lo),
        .diff_o (bnd_diff),
        .fac_o  (bnd_fac)
    );

    // one lane per channel; factor 0 red (+120), 1 green, 2 blue (-120)
    hslrgb_lane #(
        .SL_FRAC_BITS (SL_FRAC_BITS)
    ) u_lane_red (
        .aclk   (aclk),
        .ctl    (ctl),
        .lo_i   (bnd_lo),
        .diff_i (bnd_diff),
        .fac_i  (bnd_fac[0]),
        .chan_o (m_red)
    );

    hslrgb_lane #(
        .SL_FRAC_BITS (SL_FRAC_BITS)
    ) u_lane_green (
        .aclk   (aclk),
        .ctl    (ctl),
        .lo_i   (bnd_lo),
        .diff_i (bnd_diff),
        .fac_i  (bnd_fac[1]),
        .chan_o (m_green)
    );

    hslrgb_lane #(
        .SL_FRAC_BITS (SL_FRAC_BITS)
    ) u_lane_blue (
        .aclk   (aclk),
        .ctl    (ctl),
        .lo_i   (bnd_lo),
        .diff_i (bnd_diff),
        .fac_i  (bnd_fac[2]),
        .chan_o (m_blue)
    );

endmodule

// ===== src/hslrgb_chk.sv =====
// Port-level checks for hsl_to_rgb_converter, bound onto the top level.
// Depends on hslrgb_pkg and hsl_to_rgb_converter.
module hslrgb_chk import hslrgb_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [HUE_W-1:0]  s_hue_degrees,
    input logic [SL_W-1:0]   s_saturation,
    input logic [SL_W-1:0]   s_lightness,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CHAN_W-1:0] m_red,
    input logic [CHAN_W-1:0] m_green,
    input logic [CHAN_W-1:0] m_blue
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a free-running output never back-pressures the input
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    // stalled output word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue))
        else $error("output word changed under stall");

    // black in, black out on an unstalled path
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_saturation == '0 && s_lightness == '0)
            ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
            ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid && m_red == '0 && m_green == '0 && m_blue == '0)
        else $error("black pixel not black at output");

endmodule

bind hsl_to_rgb_converter hslrgb_chk u_chk (.*);
